// ----- rtl/matrix_multiply_defines.svh -----
// Assertion macros used by the checker file of the matrix product engine.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// Implication checked on the next edge, masked while reset is asserted.
`define MM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("matrix_multiply check failed");

// Implication checked on the next edge, live through reset.
`define MM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("matrix_multiply check failed");

`endif

// ----- rtl/mm_pkg.sv -----
// Package: types, codes and widths of the matrix product engine.
`default_nettype none
package mm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int DIM_W      = 4;   // dimension register width
  localparam int IDX_W      = 3;   // row / column field width
  localparam int VAL_W      = 16;  // entry field width
  localparam int PROD_W     = 36;  // product field width
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Tag that travels with each multiply through the pipeline.
  typedef struct packed {
    logic             first_k;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last_elem;
  } mac_tag_t;

endpackage
`default_nettype wire

// ----- rtl/mm_in_if.sv -----
// Interface: input channel of the matrix product engine.
`default_nettype none
interface mm_in_if
  import mm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, action, row_index, col_index, entry_value, input ready);
  modport sink   (input valid, action, row_index, col_index, entry_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/mm_out_if.sv -----
// Interface: result channel of the matrix product engine.
`default_nettype none
interface mm_out_if
  import mm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [PROD_W-1:0] product_value;
  logic                     last;

  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/mm_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/matrix_multiply.sv -----
// Top level: dense matrix product engine over two entry RAMs.
//
// Channels: in_ch carries load and compute beats, out_ch carries product
// elements; a beat moves when valid and ready are both high. cfg_we writes
// rows_a, inner_size or cols_b (index 0, 1, 2) in the same cycle; other
// indexes are dropped.
// Load beats (write A, write B) are taken one per cycle when idle and
// return nothing; an index beyond the store is dropped, action 3 is taken
// and dropped. A compute beat starts a run of rows_a x cols_b elements in
// row-major order, each the sum of inner_size products. One multiply and
// accumulate runs per cycle unless out_ch stalls, so a run issues
// rows_a * cols_b * inner_size reads; each product passes the RAM read and
// multiply registers into the accumulator, and each sum into the output
// register. The pace is set by the single read port of each entry RAM and
// the one multiplier behind them. in_ch.ready is low while a run issues
// reads; loads may follow as soon as the last read of a run is issued.
// A stalled out_ch freezes the read, multiply and accumulate stages; the
// element waits in the output register and nothing is lost.
// Reset (rst_n low, synchronous) sets all dimensions to 8 and clears the
// pipeline; RAM contents are undefined until written.
`default_nettype none
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mm_in_if.sink                      in_ch,
  mm_out_if.source                   out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MUL_W  = 2 * DATA_WIDTH;
  localparam int EXT_W  = (MUL_W > PROD_W) ? MUL_W : PROD_W;
  localparam logic [DIM_W:0] MAX_DIM_C = (DIM_W + 1)'(MAX_DIM);

  // Map register value onto 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if ({1'b0, d} > MAX_DIM_C) begin
      r = MAX_DIM_C[DIM_W-1:0];
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Configuration registers
  logic [DIM_W-1:0] rows_a_r, inner_size_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= DIM_RESET;
      inner_size_r <= DIM_RESET;
      cols_b_r     <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:     rows_a_r     <= cfg_data;
        CFG_INNER_SIZE: inner_size_r <= cfg_data;
        CFG_COLS_B:     cols_b_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] nr_m1, nk_m1, nc_m1;
  assign nr_m1 = clamp_dim(rows_a_r)     - DIM_W'(1);
  assign nk_m1 = clamp_dim(inner_size_r) - DIM_W'(1);
  assign nc_m1 = clamp_dim(cols_b_r)     - DIM_W'(1);

  // Sequencer state and loop counters
  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic             stall, adv, issue, in_acc;
  mac_tag_t         tag0;

  assign stall  = out_ch.valid && !out_ch.ready;
  assign adv    = !stall;
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.action == ACT_COMPUTE) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        issue = adv;
        if (adv) begin
          if (k_r == nk_m1) begin
            k_nxt = '0;
            if (j_r == nc_m1) begin
              j_nxt = '0;
              if (i_r == nr_m1) begin
                state_nxt = ST_IDLE;
              end else begin
                i_nxt = i_r + DIM_W'(1);
              end
            end else begin
              j_nxt = j_r + DIM_W'(1);
            end
          end else begin
            k_nxt = k_r + DIM_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign tag0.first_k   = (k_r == '0);
  assign tag0.last_k    = (k_r == nk_m1);
  assign tag0.row       = i_r[IDX_W-1:0];
  assign tag0.col       = j_r[IDX_W-1:0];
  assign tag0.last_elem = (i_r == nr_m1) && (j_r == nc_m1);

  // Load path: write ports of both RAMs
  logic                  wr_in_range, we_a, we_b;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;

  assign wr_in_range = ({2'b00, in_ch.row_index} < MAX_DIM_C) &&
                       ({2'b00, in_ch.col_index} < MAX_DIM_C);
  assign waddr = ADDR_W'(32'(in_ch.row_index) * MAX_DIM + 32'(in_ch.col_index));
  assign wdata = DATA_WIDTH'(in_ch.entry_value);
  assign we_a  = in_acc && wr_in_range && (in_ch.action == ACT_WRITE_A);
  assign we_b  = in_acc && wr_in_range && (in_ch.action == ACT_WRITE_B);

  // Read path: A[i][k] and B[k][j]
  logic [ADDR_W-1:0]     raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] a_rdata, b_rdata;

  assign raddr_a = ADDR_W'(32'(i_r) * MAX_DIM + 32'(k_r));
  assign raddr_b = ADDR_W'(32'(k_r) * MAX_DIM + 32'(j_r));

  mm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (raddr_a),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (raddr_b),
    .rdata (b_rdata)
  );

  // Multiply and accumulate stages
  logic                     v1_r, v2_r;
  mac_tag_t                 tag1_r, tag2_r;
  logic signed [MUL_W-1:0]  prod_r;
  logic signed [EXT_W-1:0]  prod_ext;
  logic signed [PROD_W-1:0] prod_lo, acc_r, acc_nxt;

  assign prod_ext = EXT_W'(prod_r);
  assign prod_lo  = prod_ext[PROD_W-1:0];
  assign acc_nxt  = (tag2_r.first_k ? '0 : acc_r) + prod_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r <= tag0;
      tag2_r <= tag1_r;
      prod_r <= $signed(a_rdata) * $signed(b_rdata);
      if (v2_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Output register: hold the element until the beat is taken
  logic                     out_valid_r, out_last_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [PROD_W-1:0] out_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r && tag2_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r && tag2_r.last_k) begin
      out_row_r  <= tag2_r.row;
      out_col_r  <= tag2_r.col;
      out_val_r  <= acc_nxt;
      out_last_r <= tag2_r.last_elem;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.last          = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/mm_checker.sv -----
// Checker: port-level assertions of the matrix product engine, with its bind.
`default_nettype none
`include "matrix_multiply_defines.svh"
module mm_checker
  import mm_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic [ACT_W-1:0]         in_action,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [IDX_W-1:0]         out_row,
  input wire logic [IDX_W-1:0]         out_col,
  input wire logic signed [PROD_W-1:0] out_value,
  input wire logic                     out_last
);
  // Reset leaves no element pending.
  `MM_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  // A compute beat blocks the input at least for the next cycle.
  `MM_ASSERT_NEXT(a_compute_blocks_in, clk, rst_n, in_valid && in_ready && in_action == ACT_COMPUTE, !in_ready)

  // A stalled element holds its value.
  `MM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_row) && $stable(out_col) && $stable(out_last))

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.out_row),
  .out_col   (out_ch.out_col),
  .out_value (out_ch.product_value),
  .out_last  (out_ch.last)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for the matrix product engine: loads, computes and checks every element.
`timescale 1ns / 1ps

module tb_top;
  import mm_pkg::*;

  // Action code that the block takes and drops; register index that it ignores.
  localparam logic [ACT_W-1:0]     ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int IDLE_PCT       = 27;    // share of cycles each side idles
  localparam int SETTLE_CYCLES  = 16;    // covers the pipeline drain after the last element
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int ITEMS_PER_PHASE = 25;
  localparam int RANDOM_PHASES   = 6;
  localparam int REPORT_LIMIT    = 10;

  // One product element as the block should emit it.
  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] value;
    logic                     last;
  } product_elem_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mm_in_if  in_ch ();
  mm_out_if out_ch ();

  matrix_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: dimension registers and both entry stores, with a
  // written flag per entry so that no compute ever reads an unwritten entry.
  logic [DIM_W-1:0]        rows_a_reg;
  logic [DIM_W-1:0]        inner_reg;
  logic [DIM_W-1:0]        cols_b_reg;
  logic signed [VAL_W-1:0] a_entries [MAX_DIM_DEF][MAX_DIM_DEF];
  logic signed [VAL_W-1:0] b_entries [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                      a_written [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                      b_written [MAX_DIM_DEF][MAX_DIM_DEF];

  product_elem_t elems_due[$];   // elements still owed by the block, oldest first
  int            fault_count;
  bit            steady_flow;    // no idling on either side while set
  bit            hold_request;   // ask the result sink for a long hold-off

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Zero and out-of-range register values fold onto the legal range.
  function automatic int eff_dim(logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  // Mostly random entries, with the two extremes of Q8.8 now and then.
  function automatic logic signed [VAL_W-1:0] rand_entry();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Work out every element of A x B for the current dimensions and queue it.
  function automatic void predict_product();
    int            nr;
    int            nk;
    int            nc;
    longint        acc;
    product_elem_t elem;
    nr = eff_dim(rows_a_reg);
    nk = eff_dim(inner_reg);
    nc = eff_dim(cols_b_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_entries[i][k]) * longint'(b_entries[k][j]);
        end
        elem.row   = IDX_W'(i);
        elem.col   = IDX_W'(j);
        elem.value = acc[PROD_W-1:0];
        elem.last  = (i == nr - 1) && (j == nc - 1);
        elems_due.push_back(elem);
      end
    end
  endfunction

  // Apply one accepted beat to the shadow state.
  function automatic void absorb_beat(logic [ACT_W-1:0] act, logic [IDX_W-1:0] r,
                                      logic [IDX_W-1:0] c, logic signed [VAL_W-1:0] v);
    case (act)
      ACT_WRITE_A: begin
        a_entries[r][c] = v;
        a_written[r][c] = 1'b1;
      end
      ACT_WRITE_B: begin
        b_entries[r][c] = v;
        b_written[r][c] = 1'b1;
      end
      ACT_COMPUTE: predict_product();
      default: ;
    endcase
  endfunction

  function automatic void report_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Compare one accepted element against the oldest one owed.
  function automatic void check_element();
    product_elem_t want;
    if (elems_due.size() == 0) begin
      report_fault($sformatf("unexpected element r%0d c%0d value %0d last %0b",
                             out_ch.out_row, out_ch.out_col, out_ch.product_value,
                             out_ch.last));
      return;
    end
    want = elems_due.pop_front();
    if (out_ch.out_row !== want.row || out_ch.out_col !== want.col ||
        out_ch.product_value !== want.value || out_ch.last !== want.last) begin
      report_fault($sformatf(
        "element mismatch: expected r%0d c%0d value %0d last %0b, got r%0d c%0d value %0d last %0b",
        want.row, want.col, want.value, want.last,
        out_ch.out_row, out_ch.out_col, out_ch.product_value, out_ch.last));
    end
  endfunction

  // Check each element beat as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_element();
  end

  // Result sink: random ready, or a long counted hold-off when asked for.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run once neither channel has moved a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d elements owed",
             WATCHDOG_LIMIT, elems_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until it
  // is taken. Valid stays high on return so that a following beat can go
  // back to back; drop_input lowers it when the sender falls quiet.
  task automatic send_beat(logic [ACT_W-1:0] act, logic [IDX_W-1:0] r,
                           logic [IDX_W-1:0] c, logic signed [VAL_W-1:0] v);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.row_index   <= r;
    in_ch.col_index   <= c;
    in_ch.entry_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    absorb_beat(act, r, c, v);
  endtask

  task automatic drop_input();
    in_ch.valid <= 1'b0;
  endtask

  // Quiesce: stop offering, wait for every owed element, then let the
  // pipeline drain before anything touches the registers.
  task automatic wait_drained();
    drop_input();
    while (elems_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three dimension registers back to back, plus the unused index.
  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_ROWS_A, CFG_INNER_SIZE, CFG_COLS_B, CFG_UNUSED};
    val = '{r, k, c, CFG_DATA_W'($urandom)};
    wait_drained();
    for (int n = 0; n < 4; n++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[n];
      cfg_data  <= val[n];
      @(posedge clk);
      case (idx[n])
        CFG_ROWS_A:     rows_a_reg = val[n];
        CFG_INNER_SIZE: inner_reg  = val[n];
        CFG_COLS_B:     cols_b_reg = val[n];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Write any entry the next compute would read but that was never written.
  task automatic fill_operands();
    int nr;
    int nk;
    int nc;
    nr = eff_dim(rows_a_reg);
    nk = eff_dim(inner_reg);
    nc = eff_dim(cols_b_reg);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_written[i][k]) send_beat(ACT_WRITE_A, IDX_W'(i), IDX_W'(k), rand_entry());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_written[k][j]) send_beat(ACT_WRITE_B, IDX_W'(k), IDX_W'(j), rand_entry());
  endtask

  // Compute beat; its index and value fields carry junk the block must ignore.
  task automatic run_product();
    fill_operands();
    send_beat(ACT_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  // Reset dimensions are 8 x 8 x 8: fill both stores, then compute while the
  // receiver holds off, so the output register, the pipeline and finally
  // the input all back up. Keep offering loads and a second compute.
  task automatic test_reset_size_backpressure();
    fill_operands();
    hold_request = 1'b1;
    run_product();
    for (int n = 0; n < 6; n++)
      send_beat(n[0] ? ACT_WRITE_B : ACT_WRITE_A, IDX_W'($urandom), IDX_W'($urandom),
                rand_entry());
    run_product();
  endtask

  // Corners: zero dimensions act as one, products of the Q8.8 extremes,
  // the unused action leaving the stores alone, dimensions above the store
  // folding to the full size, and a lopsided shape.
  task automatic test_corners();
    set_dims(4'd0, 4'd0, 4'd0);
    send_beat(ACT_WRITE_A, 3'd0, 3'd0, 16'sh8000);
    send_beat(ACT_WRITE_B, 3'd0, 3'd0, 16'sh8000);
    run_product();
    send_beat(ACT_WRITE_A, 3'd0, 3'd0, 16'sh7fff);
    run_product();
    send_beat(ACT_UNUSED, 3'd0, 3'd0, 16'sh1234);
    send_beat(ACT_UNUSED, 3'd7, 3'd7, 16'shedcb);
    run_product();
    set_dims(4'd15, 4'd15, 4'd15);
    send_beat(ACT_WRITE_A, 3'd7, 3'd7, 16'sh7fff);
    send_beat(ACT_WRITE_B, 3'd7, 3'd7, 16'sh7fff);
    send_beat(ACT_WRITE_A, 3'd7, 3'd0, 16'sh8000);
    send_beat(ACT_WRITE_B, 3'd0, 3'd7, 16'sh8000);
    run_product();
    set_dims(4'd9, 4'd1, 4'd3);
    run_product();
  endtask

  // Dimensions for a random phase: mostly small, sometimes zero, full or over.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return 4'd0;
      1:       return DIM_W'($urandom_range(9, 15));
      2:       return 4'd8;
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Random phases: new dimensions, then a stream of loads with the odd
  // compute and unused action; one phase runs with no idling at all.
  task automatic test_random_phases();
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      steady_flow = (ph == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 10) run_product();
        else if (pick < 15)
          send_beat(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        else
          send_beat(pick[0] ? ACT_WRITE_A : ACT_WRITE_B, IDX_W'($urandom),
                    IDX_W'($urandom), rand_entry());
      end
      run_product();
      wait_drained();
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_WRITE_A;
    in_ch.row_index   = '0;
    in_ch.col_index   = '0;
    in_ch.entry_value = '0;
    fault_count       = 0;
    steady_flow       = 1'b0;
    hold_request      = 1'b0;
    rows_a_reg        = DIM_RESET;
    inner_reg         = DIM_RESET;
    cols_b_reg        = DIM_RESET;
    for (int i = 0; i < MAX_DIM_DEF; i++)
      for (int j = 0; j < MAX_DIM_DEF; j++) begin
        a_written[i][j] = 1'b0;
        b_written[i][j] = 1'b0;
      end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size_backpressure();
    test_corners();
    test_random_phases();

    // Drain everything, then give the pipeline its settle time.
    wait_drained();
    if (fault_count == 0 && elems_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
